[design/rci_pkg.sv]
package rci_pkg;

  // fixed point format
  localparam int F      = 16;
  localparam int THRESH = ((1 << F) + 5) / 10;

  // square root pipeline: one result bit per stage
  localparam int SQ_STAGES = 32;
  // dividend magnitude bits and divider stage count (one quotient bit each)
  localparam int MW   = 34;
  localparam int DIVN = MW + F;
  localparam int TW   = DIVN + 1;

  // queue between front and back
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam int CFG_AW = 3;

  typedef enum logic [CFG_AW-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_AXIS_X   = 3'd3,
    CFG_AXIS_Y   = 3'd4,
    CFG_AXIS_Z   = 3'd5,
    CFG_RADIUS   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0][31:0] center;
    logic [2:0][17:0] axis;
    logic [30:0]      radius;
  } cfg_t;

  // input transaction as laid out in in_tdata
  typedef struct packed {
    logic             inside_req;
    logic [30:0]      nearest;
    logic [2:0][31:0] dir;
    logic [2:0][31:0] origin;
  } in_item_t;

  typedef struct packed {
    logic [30:0] nearest;
    logic        inside_req;
  } tag_t;

  // ray after origin offset, queued for the back end
  typedef struct packed {
    logic [2:0][31:0] off;
    logic [2:0][31:0] dir;
    tag_t             tag;
  } ray_t;

  typedef struct packed {
    logic signed [31:0] h;
    logic [30:0]        a;
    tag_t               tag;
    logic               a_zero;
    logic               q_neg;
    logic               q_zero;
  } sq_side_t;

  typedef struct packed {
    tag_t tag;
    logic a_zero;
    logic q_neg;
    logic q_zero;
    logic neg1;
    logic neg2;
  } dv_side_t;

  typedef struct packed {
    logic        degenerate;
    logic        hit;
    logic [30:0] nearest;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return {1'b0, {31{1'b1}}};
    end else if (x < -64'sd2147483648) begin
      return {1'b1, 31'b0};
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

[design/rci_fifo.sv]
module rci_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rci_pkg::ray_t push_data,
  input  logic          pop,
  output rci_pkg::ray_t pop_data,
  output logic          full,
  output logic          empty
);
  import rci_pkg::*;

  ray_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (FIFO_AW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("pop from empty queue");
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("push into full queue");
`endif

endmodule

[design/rci_front.sv]
module rci_front (
  input  logic              clk,
  input  logic              rst_n,
  input  rci_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  rci_pkg::in_item_t in_item,
  input  logic              full,
  output logic              push,
  output rci_pkg::ray_t     push_data
);
  import rci_pkg::*;

  ray_t ray_r, ray_nxt;
  logic vld_r, vld_nxt;
  logic signed [63:0] diff [3];

  assign push      = vld_r && !full;
  assign in_ready  = !vld_r || !full;
  assign push_data = ray_r;

  // origin offset from the cylinder center
  always_comb begin
    ray_nxt.dir            = in_item.dir;
    ray_nxt.tag.nearest    = in_item.nearest;
    ray_nxt.tag.inside_req = in_item.inside_req;
    for (int i = 0; i < 3; i++) begin
      diff[i]        = 64'($signed(in_item.origin[i])) - 64'($signed(cfg.center[i]));
      ray_nxt.off[i] = sat32(diff[i]);
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ray_r <= ray_nxt;
    end
  end

endmodule

[design/rci_sqrt.sv]
module rci_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       in_x,
  input  rci_pkg::sq_side_t in_side,
  output logic              out_valid,
  output logic [31:0]       out_root,
  output rci_pkg::sq_side_t out_side
);
  import rci_pkg::*;

  logic [SQ_STAGES-1:0] vld_r, vld_nxt;
  logic [63:0] x_r    [SQ_STAGES];
  logic [33:0] rem_r  [SQ_STAGES];
  logic [31:0] root_r [SQ_STAGES];
  sq_side_t    side_r [SQ_STAGES];

  logic [63:0] src_x    [SQ_STAGES];
  logic [33:0] src_rem  [SQ_STAGES];
  logic [31:0] src_root [SQ_STAGES];
  sq_side_t    src_side [SQ_STAGES];
  logic [35:0] cur      [SQ_STAGES];
  logic [35:0] trial    [SQ_STAGES];
  logic        ge       [SQ_STAGES];

  assign out_valid = vld_r[SQ_STAGES-1];
  assign out_root  = root_r[SQ_STAGES-1];
  assign out_side  = side_r[SQ_STAGES-1];
  assign vld_nxt   = {vld_r[SQ_STAGES-2:0], in_valid};

  // stage inputs: stage 0 from the ports, others from the previous stage
  always_comb begin
    src_x[0]    = in_x;
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_side[0] = in_side;
    for (int k = 1; k < SQ_STAGES; k++) begin
      src_x[k]    = x_r[k-1];
      src_rem[k]  = rem_r[k-1];
      src_root[k] = root_r[k-1];
      src_side[k] = side_r[k-1];
    end
  end

  // one root bit per stage from the next two radicand bits
  always_comb begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      cur[k]   = {src_rem[k], src_x[k][63:62]};
      trial[k] = {2'b00, src_root[k], 2'b01};
      ge[k]    = (cur[k] >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        x_r[k]    <= {src_x[k][61:0], 2'b00};
        rem_r[k]  <= ge[k] ? 34'(cur[k] - trial[k]) : cur[k][33:0];
        root_r[k] <= {src_root[k][30:0], ge[k]};
        side_r[k] <= src_side[k];
      end
    end
  end

endmodule

[design/rci_div.sv]
module rci_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [30:0]              in_a,
  input  logic [rci_pkg::DIVN-1:0] in_n1,
  input  logic [rci_pkg::DIVN-1:0] in_n2,
  input  rci_pkg::dv_side_t        in_side,
  output logic                     out_valid,
  output logic [rci_pkg::DIVN-1:0] out_q1,
  output logic [rci_pkg::DIVN-1:0] out_q2,
  output rci_pkg::dv_side_t        out_side
);
  import rci_pkg::*;

  // two restoring dividers sharing the divisor; dividend shifts out
  // of the top while quotient bits shift in at the bottom
  logic [DIVN-1:0] vld_r, vld_nxt;
  logic [30:0]     a_r   [DIVN];
  logic [DIVN-1:0] nq1_r [DIVN];
  logic [DIVN-1:0] nq2_r [DIVN];
  logic [30:0]     r1_r  [DIVN];
  logic [30:0]     r2_r  [DIVN];
  dv_side_t        side_r[DIVN];

  logic [30:0]     s_a   [DIVN];
  logic [DIVN-1:0] s_nq1 [DIVN];
  logic [DIVN-1:0] s_nq2 [DIVN];
  logic [30:0]     s_r1  [DIVN];
  logic [30:0]     s_r2  [DIVN];
  dv_side_t        s_side[DIVN];
  logic [31:0]     c1    [DIVN];
  logic [31:0]     c2    [DIVN];
  logic            g1    [DIVN];
  logic            g2    [DIVN];

  assign out_valid = vld_r[DIVN-1];
  assign out_q1    = nq1_r[DIVN-1];
  assign out_q2    = nq2_r[DIVN-1];
  assign out_side  = side_r[DIVN-1];
  assign vld_nxt   = {vld_r[DIVN-2:0], in_valid};

  always_comb begin
    s_a[0]    = in_a;
    s_nq1[0]  = in_n1;
    s_nq2[0]  = in_n2;
    s_r1[0]   = '0;
    s_r2[0]   = '0;
    s_side[0] = in_side;
    for (int k = 1; k < DIVN; k++) begin
      s_a[k]    = a_r[k-1];
      s_nq1[k]  = nq1_r[k-1];
      s_nq2[k]  = nq2_r[k-1];
      s_r1[k]   = r1_r[k-1];
      s_r2[k]   = r2_r[k-1];
      s_side[k] = side_r[k-1];
    end
  end

  // trial subtract per stage
  always_comb begin
    for (int k = 0; k < DIVN; k++) begin
      c1[k] = {s_r1[k], s_nq1[k][DIVN-1]};
      c2[k] = {s_r2[k], s_nq2[k][DIVN-1]};
      g1[k] = (c1[k] >= {1'b0, s_a[k]});
      g2[k] = (c2[k] >= {1'b0, s_a[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIVN; k++) begin
        a_r[k]    <= s_a[k];
        nq1_r[k]  <= {s_nq1[k][DIVN-2:0], g1[k]};
        nq2_r[k]  <= {s_nq2[k][DIVN-2:0], g2[k]};
        r1_r[k]   <= g1[k] ? 31'(c1[k] - {1'b0, s_a[k]}) : c1[k][30:0];
        r2_r[k]   <= g2[k] ? 31'(c2[k] - {1'b0, s_a[k]}) : c2[k][30:0];
        side_r[k] <= s_side[k];
      end
    end
  end

endmodule

[design/rci_back.sv]
module rci_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rci_pkg::cfg_t cfg,
  input  logic          in_valid,
  input  rci_pkg::ray_t in_ray,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output rci_pkg::res_t out_res
);
  import rci_pkg::*;

  logic en;
  logic [7:0] vld_r, vld_nxt;
  tag_t tag_r [7];

  // stage 0: axis products
  logic signed [49:0] pd [3], po [3];
  logic signed [33:0] s0_pd_r [3], s0_po_r [3];
  logic [2:0][31:0]   s0_dir_r, s0_off_r;
  // stage 1: axis components
  logic signed [63:0] kd_sum, ko_sum;
  logic signed [31:0] s1_kd_r, s1_ko_r;
  logic [2:0][31:0]   s1_dir_r, s1_off_r;
  // stage 2: scaled axis
  logic signed [49:0] kpd [3], kpo [3];
  logic signed [33:0] s2_kpd_r [3], s2_kpo_r [3];
  logic [2:0][31:0]   s2_dir_r, s2_off_r;
  // stage 3: projected vectors
  logic signed [63:0] wd [3], wo [3];
  logic signed [31:0] s3_dp_r [3], s3_pp_r [3];
  // stage 4: squares and cross products
  logic signed [63:0] mdd [3], mdp [3], mpp [3];
  logic [61:0]        mrr;
  logic signed [47:0] s4_dd_r [3], s4_dp_r [3], s4_pp_r [3];
  logic [45:0]        s4_rr_r;
  // stage 5: coefficients
  logic signed [63:0] a_sum, h_sum, c_sum;
  logic signed [31:0] a_sat;
  logic [30:0]        s5_a_r;
  logic signed [31:0] s5_h_r, s5_c_r;
  // stage 6: discriminant products
  logic signed [63:0] s6_hh_r, s6_ac_r;
  logic signed [31:0] s6_h_r;
  logic [30:0]        s6_a_r;
  // stage 7: discriminant
  logic signed [63:0] qv;
  logic [63:0]        s7_x_r;
  sq_side_t           s7_side_r;
  // square root
  logic               sq_valid;
  logic [31:0]        sq_root;
  sq_side_t           sq_side;
  // stage 8: root numerators
  logic signed [34:0] n1, n2, m1, m2;
  logic               s8_vld_r;
  logic [30:0]        s8_a_r;
  logic [DIVN-1:0]    s8_n1_r, s8_n2_r;
  dv_side_t           s8_side_r;
  // division
  logic               dv_valid;
  logic [DIVN-1:0]    dv_q1, dv_q2;
  dv_side_t           dv_side;
  // output
  logic signed [TW-1:0] t1, t2, tsel, tnear;
  logic               t2_neg, upd;
  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res_nxt;

  assign en        = !out_valid_r || out_ready;
  assign pop       = en && in_valid;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign vld_nxt   = {vld_r[6:0], in_valid};

  // arithmetic per stage
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd[i]  = 50'($signed(in_ray.dir[i])) * 50'($signed(cfg.axis[i]));
      po[i]  = 50'($signed(in_ray.off[i])) * 50'($signed(cfg.axis[i]));
      kpd[i] = 50'(s1_kd_r) * 50'($signed(cfg.axis[i]));
      kpo[i] = 50'(s1_ko_r) * 50'($signed(cfg.axis[i]));
      wd[i]  = 64'($signed(s2_dir_r[i])) - 64'(s2_kpd_r[i]);
      wo[i]  = 64'($signed(s2_off_r[i])) - 64'(s2_kpo_r[i]);
      mdd[i] = 64'(s3_dp_r[i]) * 64'(s3_dp_r[i]);
      mdp[i] = 64'(s3_dp_r[i]) * 64'(s3_pp_r[i]);
      mpp[i] = 64'(s3_pp_r[i]) * 64'(s3_pp_r[i]);
    end
    kd_sum = 64'(s0_pd_r[0]) + 64'(s0_pd_r[1]) + 64'(s0_pd_r[2]);
    ko_sum = 64'(s0_po_r[0]) + 64'(s0_po_r[1]) + 64'(s0_po_r[2]);
    mrr    = 62'(cfg.radius) * 62'(cfg.radius);
    a_sum  = 64'(s4_dd_r[0]) + 64'(s4_dd_r[1]) + 64'(s4_dd_r[2]);
    h_sum  = 64'(s4_dp_r[0]) + 64'(s4_dp_r[1]) + 64'(s4_dp_r[2]);
    c_sum  = 64'(s4_pp_r[0]) + 64'(s4_pp_r[1]) + 64'(s4_pp_r[2])
             - $signed({18'b0, s4_rr_r});
    a_sat  = sat32(a_sum);
    qv     = s6_hh_r - s6_ac_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_ray.tag;
      for (int k = 1; k < 7; k++) begin
        tag_r[k] <= tag_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        s0_pd_r[i]  <= pd[i][49:F];
        s0_po_r[i]  <= po[i][49:F];
        s2_kpd_r[i] <= kpd[i][49:F];
        s2_kpo_r[i] <= kpo[i][49:F];
        s3_dp_r[i]  <= sat32(wd[i]);
        s3_pp_r[i]  <= sat32(wo[i]);
        s4_dd_r[i]  <= mdd[i][63:F];
        s4_dp_r[i]  <= mdp[i][63:F];
        s4_pp_r[i]  <= mpp[i][63:F];
      end
      s0_dir_r <= in_ray.dir;
      s0_off_r <= in_ray.off;
      s1_kd_r  <= sat32(kd_sum);
      s1_ko_r  <= sat32(ko_sum);
      s1_dir_r <= s0_dir_r;
      s1_off_r <= s0_off_r;
      s2_dir_r <= s1_dir_r;
      s2_off_r <= s1_off_r;
      s4_rr_r  <= mrr[61:F];
      s5_a_r   <= a_sat[30:0];
      s5_h_r   <= sat32(h_sum);
      s5_c_r   <= sat32(c_sum);
      s6_hh_r  <= 64'(s5_h_r) * 64'(s5_h_r);
      s6_ac_r  <= 64'($signed({1'b0, s5_a_r})) * 64'(s5_c_r);
      s6_h_r   <= s5_h_r;
      s6_a_r   <= s5_a_r;
      s7_x_r           <= qv[63] ? '0 : qv;
      s7_side_r.h      <= s6_h_r;
      s7_side_r.a      <= s6_a_r;
      s7_side_r.tag    <= tag_r[6];
      s7_side_r.a_zero <= (s6_a_r == '0);
      s7_side_r.q_neg  <= qv[63];
      s7_side_r.q_zero <= (qv == '0);
    end
  end

  rci_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vld_r[7]),
    .in_x     (s7_x_r),
    .in_side  (s7_side_r),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // numerators -h + s and -h - s as sign and magnitude
  always_comb begin
    n1 = $signed({3'b000, sq_root}) - 35'($signed(sq_side.h));
    n2 = 35'sd0 - 35'($signed(sq_side.h)) - $signed({3'b000, sq_root});
    m1 = n1[34] ? -n1 : n1;
    m2 = n2[34] ? -n2 : n2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else if (en) begin
      s8_vld_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_a_r           <= sq_side.a;
      s8_n1_r          <= {m1[MW-1:0], {F{1'b0}}};
      s8_n2_r          <= {m2[MW-1:0], {F{1'b0}}};
      s8_side_r.tag    <= sq_side.tag;
      s8_side_r.a_zero <= sq_side.a_zero;
      s8_side_r.q_neg  <= sq_side.q_neg;
      s8_side_r.q_zero <= sq_side.q_zero;
      s8_side_r.neg1   <= n1[34];
      s8_side_r.neg2   <= n2[34];
    end
  end

  rci_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s8_vld_r),
    .in_a     (s8_a_r),
    .in_n1    (s8_n1_r),
    .in_n2    (s8_n2_r),
    .in_side  (s8_side_r),
    .out_valid(dv_valid),
    .out_q1   (dv_q1),
    .out_q2   (dv_q2),
    .out_side (dv_side)
  );

  // root choice and nearest update
  always_comb begin
    t1     = dv_side.neg1 ? -$signed({1'b0, dv_q1}) : $signed({1'b0, dv_q1});
    t2     = dv_side.neg2 ? -$signed({1'b0, dv_q2}) : $signed({1'b0, dv_q2});
    t2_neg = dv_side.neg2 && (dv_q2 != '0);
    if (dv_side.q_zero) begin
      tsel = t1;
    end else begin
      tsel = (t2_neg != dv_side.tag.inside_req) ? t1 : t2;
    end
    tnear = $signed({{(TW-31){1'b0}}, dv_side.tag.nearest});
    upd   = (tsel > $signed(TW'(THRESH))) && (tsel < tnear);
    res_nxt.nearest    = upd ? tsel[30:0] : dv_side.tag.nearest;
    res_nxt.hit        = upd || (tsel == tnear);
    res_nxt.degenerate = 1'b0;
    if (dv_side.a_zero) begin
      res_nxt.nearest    = dv_side.tag.nearest;
      res_nxt.hit        = 1'b0;
      res_nxt.degenerate = 1'b1;
    end else if (dv_side.q_neg) begin
      res_nxt.nearest = dv_side.tag.nearest;
      res_nxt.hit     = 1'b0;
    end
  end

  assign out_valid_nxt = en ? dv_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

[design/ray_cylinder_intersect.sv]
// Ray against infinite cylinder, Q16.16 fixed point.
// Throughput: one ray per cycle while out_tready does not stall the output;
// the back end is a 92-deep stall-as-one pipeline (32 square root stages,
// 50 divider stages) fed by a 4-entry queue.
// Reset (rst_n low, synchronous) empties the queue and pipelines and loads
// the default cylinder: center 0, axis +y, radius 1.0.
module ray_cylinder_intersect (
  input  logic                       clk,
  input  logic                       rst_n,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, nearest_in, inside_req
  input  logic [223:0]               in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // nearest_out, hit, degenerate, zero fill
  output logic [39:0]                out_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_we,
  input  logic [rci_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [31:0]                cfg_wdata
);
  import rci_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  in_item_t in_item;
  ray_t     push_data, pop_data;
  logic     push, pop, full, empty;
  res_t     res;

  assign in_item   = in_item_t'(in_tdata);
  assign out_tdata = {7'b0, res};

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_CENTER_X: cfg_nxt.center[0] = cfg_wdata;
        CFG_CENTER_Y: cfg_nxt.center[1] = cfg_wdata;
        CFG_CENTER_Z: cfg_nxt.center[2] = cfg_wdata;
        CFG_AXIS_X:   cfg_nxt.axis[0]   = cfg_wdata[17:0];
        CFG_AXIS_Y:   cfg_nxt.axis[1]   = cfg_wdata[17:0];
        CFG_AXIS_Z:   cfg_nxt.axis[2]   = cfg_wdata[17:0];
        CFG_RADIUS:   cfg_nxt.radius    = cfg_wdata[30:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center <= '0;
      cfg_r.axis   <= {18'd0, 18'd65536, 18'd0};
      cfg_r.radius <= 31'd65536;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rci_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .full     (full),
    .push     (push),
    .push_data(push_data)
  );

  rci_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .full     (full),
    .empty    (empty)
  );

  rci_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (!empty),
    .in_ray   (pop_data),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

endmodule
